>>> hw/rtl/rvq_pkg.sv
package rvq_pkg;

  localparam int unsigned VEC_WIDTH = 32;
  localparam int unsigned THR_BITS  = 28;

  localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1847;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [63:0] VEC_MASK    = (64'd1 << VEC_WIDTH) - 64'd1;

  // rotation vector, x in the lowest word
  typedef logic [2:0][31:0] vec_t;

  // quaternion, w in the lowest word
  typedef struct packed {
    logic             skip;
    logic [3:0][31:0] q;
  } res_t;

endpackage

>>> hw/rtl/rvq_core.sv
module rvq_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           in_valid_i,
  input  rvq_pkg::vec_t                  in_i,
  input  logic [rvq_pkg::THR_BITS-1:0]   thr_i,
  output logic                           out_valid_o,
  output rvq_pkg::res_t                  out_o
);

  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivASteps = 33;
  localparam int unsigned DivBSteps = 31;
  localparam int unsigned TermCnt   = 6;
  localparam int unsigned KMax      = 10;
  localparam int unsigned TlLast    = 3 * TermCnt;
  localparam int unsigned Lat       = 2 + (SqrtSteps + 1) + 4 + (TlLast + 1) + 1
                                      + (DivASteps + 1) + 2 + (SqrtSteps + 1)
                                      + (DivBSteps + 1) + 1;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqs_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [32:0] nq;
  } dv_t;

  typedef struct packed {
    sqs_t          s;
    rvq_pkg::vec_t v;
  } sa_t;

  typedef struct packed {
    logic [31:0]   theta;
    rvq_pkg::vec_t v;
    logic [64:0]   hs;
    logic [3:0]    k;
    logic          neg;
    logic [63:0]   rm;
    logic [31:0]   r;
  } ka_t;

  typedef struct packed {
    logic [31:0]        theta;
    rvq_pkg::vec_t      v;
    logic [1:0]         k;
    logic               neg;
    logic [31:0]        r2;
    logic [32:0]        ts;
    logic [32:0]        tc;
    logic [31:0]        ps;
    logic [31:0]        pc;
    logic [31:0]        es;
    logic [31:0]        ec;
    logic signed [34:0] as;
    logic signed [34:0] ac;
  } tl_t;

  typedef struct packed {
    logic [31:0]        theta;
    rvq_pkg::vec_t      v;
    logic               small_ang;
    logic signed [34:0] sn;
    logic signed [34:0] cs;
  } qa_t;

  typedef struct packed {
    logic [31:0]    dvsr;
    dv_t [2:0]      dv;
    logic [30:0]    q0m;
    logic           q0s;
    logic [2:0]     ng;
    logic           small_ang;
    rvq_pkg::vec_t  v;
  } da_t;

  typedef struct packed {
    logic [3:0][30:0] qm;
    logic [3:0]       qs;
    logic [3:0][61:0] sq;
  } pq_t;

  typedef struct packed {
    sqs_t             s;
    logic [3:0][30:0] qm;
    logic [3:0]       qs;
  } sb_t;

  typedef struct packed {
    logic [31:0]      dvsr;
    logic             skip;
    logic [3:0][30:0] qm;
    logic [3:0]       qs;
    dv_t [3:0]        dv;
  } db_t;

  function automatic logic [31:0] load_comp(logic [31:0] raw);
    logic [63:0]        m;
    logic signed [63:0] s;
    m = {32'b0, raw} & rvq_pkg::VEC_MASK;
    if (m[rvq_pkg::VEC_WIDTH-1]) m = m | ~rvq_pkg::VEC_MASK;
    s = $signed(m);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    else if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic sqs_t sqrt_step(sqs_t a, logic [63:0] b);
    sqs_t        o;
    logic [63:0] rb;
    o  = a;
    rb = a.root + b;
    if (a.rem >= rb) begin
      o.rem  = a.rem - rb;
      o.root = (a.root >> 1) + b;
    end else begin
      o.root = a.root >> 1;
    end
    return o;
  endfunction

  // one restoring step: pull the next numerator bit, shift in a quotient bit
  function automatic dv_t div_step(dv_t a, logic [31:0] d);
    dv_t         o;
    logic [32:0] t;
    logic [32:0] df;
    logic        ge;
    t  = {a.rem, a.nq[32]};
    df = t - {1'b0, d};
    ge = t >= {1'b0, d};
    o.rem = ge ? df[31:0] : t[31:0];
    o.nq  = {a.nq[31:0], ge};
    return o;
  endfunction

  logic [Lat-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[Lat-1];

  // load and square
  rvq_pkg::vec_t    v0_q;
  rvq_pkg::vec_t    v1_q;
  logic [2:0][63:0] sq1_d, sq1_q;
  sa_t              sa_q [0:SqrtSteps];
  sa_t              sa0_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq1_d[i] = {32'b0, mag32(v0_q[i])} * {32'b0, mag32(v0_q[i])};
    end
  end

  always_comb begin
    sa0_d.s.rem  = sq1_q[0] + sq1_q[1] + sq1_q[2];
    sa0_d.s.root = '0;
    sa0_d.v      = v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) v0_q[i] <= load_comp(in_i[i]);
      v1_q     <= v0_q;
      sq1_q    <= sq1_d;
      sa_q[0]  <= sa0_d;
    end
  end

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqa
    sa_t sa_d;
    always_comb begin
      sa_d   = sa_q[i];
      sa_d.s = sqrt_step(sa_q[i].s, 64'd1 << (62 - 2 * i));
    end
    always_ff @(posedge clk_i) begin
      if (en_i) sa_q[i+1] <= sa_d;
    end
  end

  // range reduction of theta/2 by multiples of pi/2
  ka_t ka_q [0:3];
  ka_t ka0_d, ka1_d, ka2_d, ka3_d;

  always_comb begin
    ka0_d       = '0;
    ka0_d.theta = sa_q[SqrtSteps].s.root[31:0];
    ka0_d.v     = sa_q[SqrtSteps].v;
    ka0_d.hs    = {1'b0, sa_q[SqrtSteps].s.root[31:0], 32'b0}
                  + {2'b0, rvq_pkg::HALF_PI_Q60[63:1]};
  end

  always_comb begin
    ka1_d   = ka_q[0];
    ka1_d.k = '0;
    for (int j = 1; j <= KMax; j++) begin
      if (ka_q[0].hs >= 65'(j) * {1'b0, rvq_pkg::HALF_PI_Q60}) ka1_d.k = ka1_d.k + 4'd1;
    end
  end

  logic [64:0] kp, hv, kdiff;
  always_comb begin
    ka2_d     = ka_q[1];
    kp        = {61'b0, ka_q[1].k} * {1'b0, rvq_pkg::HALF_PI_Q60};
    hv        = {1'b0, ka_q[1].theta, 32'b0};
    ka2_d.neg = hv < kp;
    kdiff     = ka2_d.neg ? (kp - hv) : (hv - kp);
    ka2_d.rm  = kdiff[63:0];
  end

  logic [63:0] rnd;
  always_comb begin
    ka3_d   = ka_q[2];
    rnd     = ka_q[2].rm + (64'd1 << 27);
    ka3_d.r = rnd[59:28];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ka_q[0] <= ka0_d;
      ka_q[1] <= ka1_d;
      ka_q[2] <= ka2_d;
      ka_q[3] <= ka3_d;
    end
  end

  // Taylor series, three stages per term: product, reciprocal estimate, correction
  tl_t         tl_q [0:TlLast];
  tl_t         tl0_d;
  logic [63:0] rr;

  always_comb begin
    tl0_d       = '0;
    rr          = {32'b0, ka_q[3].r} * {32'b0, ka_q[3].r};
    tl0_d.theta = ka_q[3].theta;
    tl0_d.v     = ka_q[3].v;
    tl0_d.k     = ka_q[3].k[1:0];
    tl0_d.neg   = ka_q[3].neg;
    tl0_d.r2    = rr[63:32];
    tl0_d.ts    = {1'b0, ka_q[3].r};
    tl0_d.tc    = 33'h1_0000_0000;
    tl0_d.as    = $signed({3'b0, ka_q[3].r});
    tl0_d.ac    = 35'sh1_0000_0000;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) tl_q[0] <= tl0_d;
  end

  for (genvar n = 0; n < TermCnt; n++) begin : g_term
    localparam logic [31:0] DivS  = 32'((2 * n + 2) * (2 * n + 3));
    localparam logic [31:0] DivC  = 32'((2 * n + 1) * (2 * n + 2));
    localparam logic [31:0] RecS  = 32'((64'd1 << 32) / 64'(DivS));
    localparam logic [31:0] RecC  = 32'((64'd1 << 32) / 64'(DivC));
    localparam bit          Minus = (n % 2) == 0;

    tl_t         a_d, b_d, c_d;
    logic [64:0] prd_s, prd_c;
    logic [63:0] est_s, est_c;
    logic [31:0] rem_s, rem_c, quo_s, quo_c;

    always_comb begin
      a_d    = tl_q[3*n];
      prd_s  = 65'(tl_q[3*n].ts) * 65'(tl_q[3*n].r2);
      prd_c  = 65'(tl_q[3*n].tc) * 65'(tl_q[3*n].r2);
      a_d.ps = prd_s[63:32];
      a_d.pc = prd_c[63:32];
    end

    always_comb begin
      b_d    = tl_q[3*n+1];
      est_s  = {32'b0, tl_q[3*n+1].ps} * {32'b0, RecS};
      est_c  = {32'b0, tl_q[3*n+1].pc} * {32'b0, RecC};
      b_d.es = est_s[63:32];
      b_d.ec = est_c[63:32];
    end

    // the estimate is at most one short of the true quotient
    always_comb begin
      c_d   = tl_q[3*n+2];
      rem_s = c_d.ps - (c_d.es * DivS);
      rem_c = c_d.pc - (c_d.ec * DivC);
      quo_s = c_d.es + {31'b0, rem_s >= DivS};
      quo_c = c_d.ec + {31'b0, rem_c >= DivC};
      c_d.ts = {1'b0, quo_s};
      c_d.tc = {1'b0, quo_c};
      c_d.as = Minus ? (c_d.as - $signed({3'b0, quo_s})) : (c_d.as + $signed({3'b0, quo_s}));
      c_d.ac = Minus ? (c_d.ac - $signed({3'b0, quo_c})) : (c_d.ac + $signed({3'b0, quo_c}));
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tl_q[3*n+1] <= a_d;
        tl_q[3*n+2] <= b_d;
        tl_q[3*n+3] <= c_d;
      end
    end
  end

  // quadrant selection
  qa_t                qa_d, qa_q;
  logic signed [34:0] sv;

  always_comb begin
    qa_d.theta     = tl_q[TlLast].theta;
    qa_d.v         = tl_q[TlLast].v;
    qa_d.small_ang = (tl_q[TlLast].theta == 32'd0)
                     || (tl_q[TlLast].theta < {4'b0, thr_i});
    sv = tl_q[TlLast].neg ? -tl_q[TlLast].as : tl_q[TlLast].as;
    case (tl_q[TlLast].k)
      2'd0: begin
        qa_d.sn = sv;
        qa_d.cs = tl_q[TlLast].ac;
      end
      2'd1: begin
        qa_d.sn = tl_q[TlLast].ac;
        qa_d.cs = -sv;
      end
      2'd2: begin
        qa_d.sn = -sv;
        qa_d.cs = -tl_q[TlLast].ac;
      end
      default: begin
        qa_d.sn = -tl_q[TlLast].ac;
        qa_d.cs = sv;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) qa_q <= qa_d;
  end

  // vector part: |sin| * |rot| / theta, rounded
  da_t         da_q [0:DivASteps];
  da_t         da0_d;
  logic [34:0] msn, mcs;
  logic [63:0] numa;
  logic [33:0] rq0;

  always_comb begin
    da0_d           = '0;
    msn             = qa_q.sn[34] ? 35'(-qa_q.sn) : 35'(qa_q.sn);
    mcs             = qa_q.cs[34] ? 35'(-qa_q.cs) : 35'(qa_q.cs);
    numa            = '0;
    da0_d.dvsr      = qa_q.theta;
    da0_d.small_ang = qa_q.small_ang;
    da0_d.v         = qa_q.v;
    for (int i = 0; i < 3; i++) begin
      numa = {31'b0, msn[32:0]} * {32'b0, mag32(qa_q.v[i])} + {33'b0, qa_q.theta[31:1]};
      da0_d.dv[i].rem = {1'b0, numa[63:33]};
      da0_d.dv[i].nq  = numa[32:0];
      da0_d.ng[i]     = qa_q.sn[34] ^ qa_q.v[i][31];
    end
    rq0       = {1'b0, mcs[32:0]} + 34'd2;
    da0_d.q0m = rq0[32:2];
    da0_d.q0s = qa_q.cs[34];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) da_q[0] <= da0_d;
  end

  for (genvar i = 0; i < DivASteps; i++) begin : g_diva
    da_t da_d;
    always_comb begin
      da_d = da_q[i];
      for (int l = 0; l < 3; l++) da_d.dv[l] = div_step(da_q[i].dv[l], da_q[i].dvsr);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) da_q[i+1] <= da_d;
    end
  end

  // round to Q1.30, square
  pq_t         pq2_d, pq2_q, pq3_d, pq3_q;
  logic [33:0] rqv;
  logic [31:0] mv;

  always_comb begin
    pq2_d       = '0;
    rqv         = '0;
    mv          = '0;
    pq2_d.qm[0] = da_q[DivASteps].q0m;
    pq2_d.qs[0] = da_q[DivASteps].q0s;
    for (int i = 0; i < 3; i++) begin
      if (da_q[DivASteps].small_ang) begin
        mv            = mag32(da_q[DivASteps].v[i]);
        pq2_d.qm[i+1] = {mv[28:0], 2'b00};
        pq2_d.qs[i+1] = da_q[DivASteps].v[i][31];
      end else begin
        rqv           = {1'b0, da_q[DivASteps].dv[i].nq} + 34'd2;
        pq2_d.qm[i+1] = rqv[32:2];
        pq2_d.qs[i+1] = da_q[DivASteps].ng[i];
      end
    end
  end

  always_comb begin
    pq3_d = pq2_q;
    for (int j = 0; j < 4; j++) begin
      pq3_d.sq[j] = {31'b0, pq2_q.qm[j]} * {31'b0, pq2_q.qm[j]};
    end
  end

  sb_t sb_q [0:SqrtSteps];
  sb_t sb0_d;

  always_comb begin
    sb0_d.s.rem  = {2'b0, pq3_q.sq[0]} + {2'b0, pq3_q.sq[1]}
                   + {2'b0, pq3_q.sq[2]} + {2'b0, pq3_q.sq[3]};
    sb0_d.s.root = '0;
    sb0_d.qm     = pq3_q.qm;
    sb0_d.qs     = pq3_q.qs;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pq2_q   <= pq2_d;
      pq3_q   <= pq3_d;
      sb_q[0] <= sb0_d;
    end
  end

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqb
    sb_t sb_d;
    always_comb begin
      sb_d   = sb_q[i];
      sb_d.s = sqrt_step(sb_q[i].s, 64'd1 << (62 - 2 * i));
    end
    always_ff @(posedge clk_i) begin
      if (en_i) sb_q[i+1] <= sb_d;
    end
  end

  // normalise: |q| * 2^30 / length, rounded
  db_t         db_q [0:DivBSteps];
  db_t         db0_d;
  logic [31:0] len;
  logic [60:0] numb;

  always_comb begin
    len        = sb_q[SqrtSteps].s.root[31:0];
    numb       = '0;
    db0_d.dvsr = len;
    db0_d.skip = len == 32'd0;
    db0_d.qm   = sb_q[SqrtSteps].qm;
    db0_d.qs   = sb_q[SqrtSteps].qs;
    for (int j = 0; j < 4; j++) begin
      numb = {sb_q[SqrtSteps].qm[j], 30'b0} + {30'b0, len[31:1]};
      db0_d.dv[j].rem = {2'b0, numb[60:31]};
      db0_d.dv[j].nq  = {numb[30:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) db_q[0] <= db0_d;
  end

  for (genvar i = 0; i < DivBSteps; i++) begin : g_divb
    db_t db_d;
    always_comb begin
      db_d = db_q[i];
      for (int l = 0; l < 4; l++) db_d.dv[l] = div_step(db_q[i].dv[l], db_q[i].dvsr);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) db_q[i+1] <= db_d;
    end
  end

  // saturate, apply sign; pass the raw parts through when the length is zero
  rvq_pkg::res_t out_d, out_q;
  logic [30:0]   mq, mg;

  always_comb begin
    out_d.skip = db_q[DivBSteps].skip;
    mq         = '0;
    mg         = '0;
    for (int j = 0; j < 4; j++) begin
      mq = db_q[DivBSteps].dv[j].nq[30:0];
      if (mq > rvq_pkg::ONE_Q30) mq = rvq_pkg::ONE_Q30;
      mg = db_q[DivBSteps].skip ? db_q[DivBSteps].qm[j] : mq;
      if (mg > rvq_pkg::ONE_Q30) mg = rvq_pkg::ONE_Q30;
      out_d.q[j] = db_q[DivBSteps].qs[j] ? (~{1'b0, mg} + 32'd1) : {1'b0, mg};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

>>> hw/rtl/rotation_vector_to_quaternion_top.sv
// Channel   Dir  Bits  Contents
// s_axis    in   96    rot_x, rot_y, rot_z (Q4.27)
// m_axis    out  128   quat_w, quat_x, quat_y, quat_z (Q1.30); tuser normalize_skipped
// cfg       in   28    small_angle_threshold (Q1.27), write only
//
// One transaction enters per cycle while the skid register is empty; a result
// passes through the two 32-step square-root pipelines and the 33- and 31-step
// divider pipelines. Reset clears the pipeline, output and skid valid bits and
// loads the threshold with 1. A stall on m_axis freezes the pipeline once the
// skid register is full; s_axis_tready comes straight from that register.
module rotation_vector_to_quaternion_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [95:0]                   s_axis_tdata,   // rot_x, rot_y, rot_z
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [127:0]                  m_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic [0:0]                    m_axis_tuser,   // normalize_skipped
  input  logic                          cfg_we_i,
  input  logic [rvq_pkg::THR_BITS-1:0]  cfg_wdata_i
);

  logic [rvq_pkg::THR_BITS-1:0] thr_q;
  logic                         en;
  logic                         pipe_valid;
  rvq_pkg::res_t                pipe_res;
  rvq_pkg::vec_t                in_vec;

  logic          out_v_d, out_v_q, skid_v_d, skid_v_q;
  rvq_pkg::res_t out_d, out_q, skid_d, skid_q;
  logic          pop, push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= {{(rvq_pkg::THR_BITS-1){1'b0}}, 1'b1};
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign en            = !skid_v_q;
  assign s_axis_tready = en;
  assign in_vec        = s_axis_tdata;

  rvq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (s_axis_tvalid),
    .in_i        (in_vec),
    .thr_i       (thr_q),
    .out_valid_o (pipe_valid),
    .out_o       (pipe_res)
  );

  assign pop  = out_v_q && m_axis_tready;
  assign push = en && pipe_valid;

  // park a transaction in the skid register when the output is held
  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (pop) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (push) begin
      if (!out_v_q || pop) begin
        out_v_d = 1'b1;
        out_d   = pipe_res;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = pipe_res;
      end
    end else if (pop) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q.q;
  assign m_axis_tuser  = out_q.skip;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         cfg_we_i = 1'b0;
  logic [rvq_pkg::THR_BITS-1:0] cfg_wdata_i = '0;

  localparam int LATENCY    = 161;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM   = 776;
  localparam logic [63:0] HALF_PI = 64'h1921_FB54_442D_1847;
  localparam longint ONE = 64'sd1073741824;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_e;

  typedef struct packed {
    logic [3:0][31:0] q;
    logic             skip;
  } quat_t;

  // directed row: rotation vector (z, y, x from the top), whether the result is typed in
  typedef struct packed {
    logic [2:0][31:0] rv;
    bit               typed;
    quat_t            want;
  } dir_row_t;

  // zero rotation: w = 1.0, vector part zero, normalised
  localparam quat_t ZERO_VEC_RES = {96'h0, 32'h4000_0000, 1'b0};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rotation_vector_to_quaternion_top u_top (.*);

  quat_t  quat_queue[$];
  logic [27:0] angle_thr = 28'd1;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_off = 1'b0;
  int     n_errors = 0;
  int     n_results = 0;
  int     n_skipped = 0;
  int     idle_cycles = 0;

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint round_q30(longint v);
    longint m;
    m = longint'((mag(v) + 2) >> 2);
    return v < 0 ? -m : m;
  endfunction

  function automatic void half_angle_sincos(logic [63:0] theta, output longint sn,
                                            output longint cs);
    logic [63:0] h, k, kp, rm, r, r2, t;
    logic        neg;
    longint      s, c;
    h   = theta << 32;
    k   = (h + (HALF_PI >> 1)) / HALF_PI;
    kp  = k * HALF_PI;
    neg = h < kp;
    rm  = neg ? kp - h : h - kp;
    r   = (rm + (64'd1 << 27)) >> 28;
    r2  = (r * r) >> 32;
    t   = r;
    s   = longint'(r);
    for (int n = 1; n <= 6; n++) begin
      t = ((t * r2) >> 32) / ((2 * n) * (2 * n + 1));
      s += n[0] ? -longint'(t) : longint'(t);
    end
    t = 64'd1 << 32;
    c = longint'(t);
    for (int n = 1; n <= 6; n++) begin
      t = ((t * r2) >> 32) / ((2 * n - 1) * (2 * n));
      c += n[0] ? -longint'(t) : longint'(t);
    end
    if (neg) s = -s;
    case (k[1:0])
      2'd0: begin sn = s; cs = c; end
      2'd1: begin sn = c; cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  function automatic quat_t exp_map(logic [95:0] rv);
    longint      v[3], q[4], sn, cs, r;
    logic [63:0] sum, theta, len, m;
    quat_t       res;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'($signed(rv[32*i +: 32]));
      sum += mag(v[i]) * mag(v[i]);
    end
    theta = isqrt(sum);
    half_angle_sincos(theta, sn, cs);
    q[0] = cs;
    for (int i = 0; i < 3; i++) begin
      if (theta == 0 || theta < angle_thr) begin
        q[i+1] = v[i] * 16;
      end else begin
        m = (mag(sn) * mag(v[i]) + (theta >> 1)) / theta;
        q[i+1] = ((sn < 0) != (v[i] < 0)) ? -longint'(m) : longint'(m);
      end
    end
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      q[i] = round_q30(q[i]);
      sum += mag(q[i]) * mag(q[i]);
    end
    len = isqrt(sum);
    res.skip = (len == 0);
    for (int i = 0; i < 4; i++) begin
      r = q[i];
      if (!res.skip) begin
        m = ((mag(q[i]) << 30) + (len >> 1)) / len;
        if (m > ONE) m = ONE;
        r = q[i] < 0 ? -longint'(m) : longint'(m);
      end
      if (r > ONE) r = ONE;
      if (r < -ONE) r = -ONE;
      res.q[i] = r[31:0];
    end
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    $display("mismatch %0d: %s got %h expected %h", n_results, what, got, want);
  endtask

  // result checker
  always @(posedge clk_i) begin
    quat_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (quat_queue.size() == 0) begin
        report("unexpected transaction", m_axis_tdata[31:0], 32'h0);
      end else begin
        want = quat_queue.pop_front();
        for (int i = 0; i < 4; i++)
          if (m_axis_tdata[32*i +: 32] !== want.q[i])
            report($sformatf("quat[%0d]", i), m_axis_tdata[32*i +: 32], want.q[i]);
        if (m_axis_tuser[0] !== want.skip)
          report("normalize_skipped", {31'd0, m_axis_tuser[0]}, {31'd0, want.skip});
        n_skipped += want.skip;
      end
      n_results++;
    end
  end

  // receiver readiness
  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || !rst_ni || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // tvalid stays high from one transaction to the next unless the sender idles
  task automatic send(logic [95:0] rv, bit typed = 1'b0, quat_t want = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rv;
    quat_queue.push_back(typed ? want : exp_map(rv));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [27:0] thr);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    angle_thr    = thr;
  endtask

  function automatic logic [31:0] rand_component();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(65535)) - 32768);
      3: return 32'($signed($urandom_range(1 << 26)) - (1 << 25));
      default: return 32'($signed($urandom_range(1 << 28)) - (1 << 27));
    endcase
  endfunction

  // directed rows: {z, y, x}, typed flag, typed result
  dir_row_t directed_rows[] = '{
    '{{32'h0, 32'h0, 32'h0}, 1'b1, ZERO_VEC_RES},
    '{{32'h0, 32'h0, 32'h1}, 1'b0, '0},
    '{{32'h0, 32'h0, 32'hffff_ffff}, 1'b0, '0},
    '{{32'h0, 32'h0, 32'h7fff_ffff}, 1'b0, '0},
    '{{32'h0, 32'h0, 32'h8000_0000}, 1'b0, '0},
    '{{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 1'b0, '0},
    '{{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, '0},
    '{{32'h0, 32'h0, 32'h1921_fb54}, 1'b0, '0},
    '{{32'h0, 32'h3243_f6a8, 32'h0}, 1'b0, '0},
    '{{32'h6487_ed51, 32'h0, 32'h0}, 1'b0, '0},
    '{{32'h0, 32'h0, 32'h9b78_12af}, 1'b0, '0},
    '{{32'h0800_0000, 32'hf800_0000, 32'h0800_0000}, 1'b0, '0},
    '{{32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0003}, 1'b0, '0},
    '{{32'h0000_0010, 32'hffff_fff0, 32'h0000_0008}, 1'b0, '0},
    '{{32'h0400_0000, 32'h0, 32'h0}, 1'b0, '0}
  };

  // thresholds for each pass of the table; zero and the top value are the extremes
  logic [27:0] thr_list[] = '{28'd1, 28'd0, 28'h800_0000, 28'hfff_ffff, 28'h10_0000};

  initial begin
    phase_e ph;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every row at each threshold; the zero vector gives the identity quaternion at any threshold
    foreach (thr_list[t]) begin
      if (t != 0) write_threshold(thr_list[t]);
      foreach (directed_rows[i])
        send(directed_rows[i].rv, directed_rows[i].typed, directed_rows[i].want);
      drain();
    end

    for (int p = 0; p < 4; p++) begin
      ph = phase_e'(p);
      send_idle_pct  = (ph == PH_SEND_IDLE) ? 54 : (ph == PH_BOTH) ? 7 : 0;
      recv_stall_pct = (ph == PH_RECV_STALL) ? 54 : (ph == PH_BOTH) ? 7 : 0;
      write_threshold(p == 3 ? 28'd0 : 28'($urandom_range(28'h800_0000)));
      if (ph == PH_FREE) begin
        // hold the receiver off long enough for the pipeline to fill and stall
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < N_RANDOM / 4; i++)
        send({rand_component(), rand_component(), rand_component()});
      drain();
    end

    $display("covered %0d results, %0d with normalisation skipped, thresholds incl. 0 and max",
             n_results, n_skipped);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
